/* sv/lcba_pkg.sv */
// Package for the light color breathing animator.
// Holds the raised cosine table, built at elaboration, and the lane control type.
// No dependencies.
`timescale 1ns / 1ps

package lcba_pkg;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef logic [15:0] cos_table_t [TABLE_DEPTH];

	typedef struct packed {
		logic start;
		logic hold;
		logic mult;
	} lcba_chan_ctl_t;

	// cos(w*pi/2), w in Q30, Horner form of the Taylor series, Q30 result
	function automatic logic [63:0] quarter_cos(input logic [63:0] w);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] h;
		logic [63:0] p;
		t = (w * Q30_HALF_PI) >> 30;
		t2 = (t * t) >> 30;
		h = Q30_ONE - t2 / 64'd90;
		h = Q30_ONE - ((t2 * h) >> 30) / 64'd56;
		h = Q30_ONE - ((t2 * h) >> 30) / 64'd30;
		h = Q30_ONE - ((t2 * h) >> 30) / 64'd12;
		p = ((t2 * h) >> 30) / 64'd2;
		return (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
	endfunction

	function automatic logic [15:0] table_entry(input logic [63:0] i);
		logic [63:0] f;
		logic [1:0] quad;
		logic [63:0] w;
		logic [63:0] c;
		logic [63:0] r;
		logic [63:0] q16;
		f = (i << 32) / 64'(TABLE_DEPTH);
		quad = f[31:30];
		w = f & (Q30_ONE - 64'd1);
		case (quad)
			2'd0: begin
				c = quarter_cos(w);
				r = (Q30_ONE + c) / 64'd2;
			end
			2'd1: begin
				c = quarter_cos(Q30_ONE - w);
				r = (Q30_ONE - c) / 64'd2;
			end
			2'd2: begin
				c = quarter_cos(w);
				r = (Q30_ONE - c) / 64'd2;
			end
			default: begin
				c = quarter_cos(Q30_ONE - w);
				r = (Q30_ONE + c) / 64'd2;
			end
		endcase
		q16 = (r + 64'd8192) >> 14;
		if (q16 > 64'd65535) begin
			q16 = 64'd65535;
		end
		return q16[15:0];
	endfunction

	function automatic cos_table_t build_cos_table();
		cos_table_t tab;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tab[i] = table_entry(64'(i));
		end
		return tab;
	endfunction

	localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* sv/light_color_breathing_animator.sv */
// Top level of the light color breathing animator: configuration registers,
// phase accumulator, cosine ROM and three lcba_chan lanes. Depends on lcba_pkg.
`timescale 1ns / 1ps

// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 speed, 1 radius,
//   2 base_color, 3 anim_color, 4 multiply_mode, 5 hold_mask) and cfg_data.
//   cfg_ready is always high; other indexes are ignored.
//   Input: one item per tick carries elapsed_time, taken when in_valid is high
//   and in_stall is low. in_stall is high while an item is in work.
//   Output: red_out, green_out, blue_out, held under out_valid until a cycle
//   with out_stall low.
//   Processing: the 16-step serial elapsed*speed product, the 16-step
//   serial level*radius product and the lane sequence (8-bit anim product,
//   8-bit base product, 8-step divide by 255) run in turn; one item is in
//   work at a time. A finished item waits in the output register, so the
//   next item is taken while it is stalled; a second result waits in the
//   lanes until it drains.
//   Reset: registers take their defaults, phase clears, output is empty.

module light_color_breathing_animator import lcba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] elapsed_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [2:0] {
		REG_SPEED = 3'd0,
		REG_RADIUS = 3'd1,
		REG_BASE_COLOR = 3'd2,
		REG_ANIM_COLOR = 3'd3,
		REG_MULTIPLY_MODE = 3'd4,
		REG_HOLD_MASK = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_STEP,
		T_PHASE,
		T_ROM,
		T_LR,
		T_CHAN,
		T_OUT
	} state_t;

	logic [15:0] speed_q;
	logic [15:0] radius_q;
	logic [23:0] base_q;
	logic [23:0] anim_q;
	logic        mult_q;
	logic [2:0]  hold_q;

	state_t      state_q;
	logic [3:0]  cnt_q;
	logic [15:0] el_sh_q;
	logic [23:0] prod_q;
	logic [23:0] phase_q;
	logic [15:0] level_q;
	logic [15:0] rad_sh_q;
	logic [31:0] lr_q;
	logic        chan_start_q;
	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	logic [7:0]  chan_res [3];
	logic [2:0]  chan_done;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != T_IDLE);
	assign out_valid = out_valid_q;
	assign red_out = red_q;
	assign green_out = green_q;
	assign blue_out = blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd256;
			radius_q <= 16'd4096;
			base_q <= 24'h000000;
			anim_q <= 24'hFFFFFF;
			mult_q <= 1'b0;
			hold_q <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_SPEED:         speed_q <= cfg_data[15:0];
				REG_RADIUS:        radius_q <= cfg_data[15:0];
				REG_BASE_COLOR:    base_q <= cfg_data;
				REG_ANIM_COLOR:    anim_q <= cfg_data;
				REG_MULTIPLY_MODE: mult_q <= cfg_data[0];
				REG_HOLD_MASK:     hold_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			cnt_q <= '0;
			el_sh_q <= '0;
			prod_q <= '0;
			phase_q <= '0;
			level_q <= '0;
			rad_sh_q <= '0;
			lr_q <= '0;
			chan_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else begin
			chan_start_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != T_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						el_sh_q <= elapsed_time;
						prod_q <= '0;
						cnt_q <= '0;
						state_q <= T_STEP;
					end
				end
				T_STEP: begin
					prod_q <= {prod_q[22:0], 1'b0} + (el_sh_q[15] ? {8'b0, speed_q} : 24'b0);
					el_sh_q <= {el_sh_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= T_PHASE;
					end
				end
				T_PHASE: begin
					phase_q <= phase_q + prod_q;
					state_q <= T_ROM;
				end
				T_ROM: begin
					level_q <= COS_TABLE[phase_q[23 -: IDX_W]];
					rad_sh_q <= radius_q;
					lr_q <= '0;
					cnt_q <= '0;
					state_q <= T_LR;
				end
				T_LR: begin
					lr_q <= {lr_q[30:0], 1'b0} + (rad_sh_q[15] ? {16'b0, level_q} : 32'b0);
					rad_sh_q <= {rad_sh_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						chan_start_q <= 1'b1;
						state_q <= T_CHAN;
					end
				end
				T_CHAN: begin
					// lanes still show the previous item while the start pulse is out
					if (!chan_start_q && (&chan_done)) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (!out_valid_q || !out_stall) begin
						red_q <= chan_res[0];
						green_q <= chan_res[1];
						blue_q <= chan_res[2];
						out_valid_q <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// lane 0 red, lane 1 green, lane 2 blue
	for (genvar g = 0; g < 3; g++) begin : g_lane
		lcba_chan_ctl_t ctl;

		assign ctl.start = chan_start_q;
		assign ctl.hold = hold_q[g];
		assign ctl.mult = mult_q;

		lcba_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.lr     (lr_q),
			.base   (base_q[23 - 8 * g -: 8]),
			.anim   (anim_q[23 - 8 * g -: 8]),
			.res    (chan_res[g]),
			.done   (chan_done[g])
		);
	end

endmodule

/* sv/lcba_chan.sv */
// One color lane: bit-serial offset and base products, serial divide by 255,
// add-mode rounding and saturation, and hold mode passing base through. Depends on lcba_pkg.
`timescale 1ns / 1ps

module lcba_chan import lcba_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  lcba_chan_ctl_t ctl,
	input  logic [31:0]    lr,
	input  logic [7:0]     base,
	input  logic [7:0]     anim,
	output logic [7:0]     res,
	output logic           done
);

	localparam logic [32:0] MUL_BIAS = 33'd522240;   // 255*2048
	localparam logic [20:0] SAT_LIMIT = 21'd65280;   // 255*256
	localparam logic [15:0] DIV_START = 16'd32640;   // 255 << 7

	typedef enum logic [2:0] {
		S_IDLE,
		S_ANIM,
		S_BASE,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	state_t      state_q;
	logic [39:0] acc_q;
	logic [7:0]  anim_sh_q;
	logic [31:0] prod_q;
	logic [7:0]  base_sh_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [7:0]  quo_q;
	logic        sat_q;
	logic [2:0]  cnt_q;

	logic [23:0] off;
	logic [32:0] xsum;
	logic [20:0] y;
	logic [24:0] off_rnd;
	logic [13:0] add_sum;
	logic [7:0]  add_sat;

	assign off = acc_q[39:16];
	assign xsum = {1'b0, prod_q} + MUL_BIAS;
	assign y = xsum[32:12];
	assign off_rnd = {1'b0, off} + 25'd2048;
	assign add_sum = {6'b0, base} + {1'b0, off_rnd[24:12]};
	assign add_sat = (add_sum > 14'd255) ? 8'd255 : add_sum[7:0];

	always_comb begin
		if (ctl.hold) begin
			res = base;
		end else if (ctl.mult) begin
			res = sat_q ? 8'd255 : quo_q;
		end else begin
			res = add_sat;
		end
	end

	assign done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= '0;
			anim_sh_q <= '0;
			prod_q <= '0;
			base_sh_q <= '0;
			rem_q <= '0;
			div_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			acc_q <= '0;
			anim_sh_q <= anim;
			cnt_q <= '0;
			state_q <= S_ANIM;
		end else begin
			case (state_q)
				S_ANIM: begin
					acc_q <= {acc_q[38:0], 1'b0} + (anim_sh_q[7] ? {8'b0, lr} : 40'b0);
					anim_sh_q <= {anim_sh_q[6:0], 1'b0};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						prod_q <= '0;
						base_sh_q <= base;
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					prod_q <= {prod_q[30:0], 1'b0} + (base_sh_q[7] ? {8'b0, off} : 32'b0);
					base_sh_q <= {base_sh_q[6:0], 1'b0};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					sat_q <= (y >= SAT_LIMIT);
					rem_q <= y[15:0];
					div_q <= DIV_START;
					quo_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_q >= div_q) begin
						rem_q <= rem_q - div_q;
						quo_q <= {quo_q[6:0], 1'b1};
					end else begin
						quo_q <= {quo_q[6:0], 1'b0};
					end
					div_q <= {1'b0, div_q[15:1]};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= S_DONE;
					end
				end
				S_IDLE, S_DONE: begin
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_light_color_breathing_animator.sv */
// Testbench for light_color_breathing_animator: directed table, then random ticks
// under random register settings, checked against a local breathing color predictor.
// Depends only on the block's RTL.
`timescale 1ns / 1ps

module tb_light_color_breathing_animator;

	localparam int unsigned COS_STEPS = 1024;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RANDOM_TICKS = 800;
	localparam logic [63:0] Q30 = 64'd1073741824;
	localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_SPEED,
		REG_RADIUS,
		REG_BASE_COLOR,
		REG_ANIM_COLOR,
		REG_MULT_MODE,
		REG_HOLD_MASK,
		REG_RSVD6,
		REG_RSVD7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		bit is_cfg;
		reg_idx_t idx;
		logic [23:0] value;
		bit known;
		rgb_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] elapsed_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	light_color_breathing_animator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.elapsed_time(elapsed_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [15:0] cos_lut [COS_STEPS];
	logic [23:0] phase;
	logic [15:0] speed_r;
	logic [15:0] radius_r;
	logic [23:0] base_r;
	logic [23:0] anim_r;
	logic mult_r;
	logic [2:0] hold_r;

	rgb_t pending_colors [$];
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	// cos(w*pi/2) in Q30, Horner over the Taylor terms
	function automatic logic [63:0] cos_q30(input logic [63:0] w);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] h;
		logic [63:0] p;
		int unsigned divs [4] = '{90, 56, 30, 12};
		t = (w * Q30_QUARTER_TURN) >> 30;
		t2 = (t * t) >> 30;
		h = Q30;
		foreach (divs[k]) begin
			h = Q30 - ((t2 * h) >> 30) / 64'(divs[k]);
		end
		p = ((t2 * h) >> 30) / 64'd2;
		return (p > Q30) ? 64'd0 : Q30 - p;
	endfunction

	function automatic logic [15:0] raised_cos_q16(input int unsigned k);
		logic [63:0] turn;
		logic [63:0] frac;
		logic [63:0] c;
		logic [63:0] half;
		logic [63:0] q;
		logic [1:0] quad;
		turn = (64'(k) << 32) / 64'(COS_STEPS);
		quad = turn[31:30];
		frac = {34'd0, turn[29:0]};
		if (quad[0]) begin
			frac = Q30 - frac;
		end
		c = cos_q30(frac);
		half = (quad[0] ^ quad[1]) ? (Q30 - c) / 64'd2 : (Q30 + c) / 64'd2;
		q = (half + 64'd8192) >> 14;
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [7:0] shade_channel(input logic [7:0] base, input logic [7:0] anim,
			input logic [15:0] level, input logic hold);
		logic [63:0] off;
		logic [63:0] v;
		if (hold) begin
			return base;
		end
		off = (64'(anim) * 64'(level) * 64'(radius_r)) >> 16;
		if (mult_r) begin
			v = (64'(base) * off + 64'd522240) / 64'd1044480;
		end else begin
			v = (64'(base) * 64'd4096 + off + 64'd2048) >> 12;
		end
		return (v > 64'd255) ? 8'hFF : v[7:0];
	endfunction

	function automatic rgb_t breathe_tick(input logic [15:0] et);
		logic [63:0] idx;
		logic [15:0] level;
		rgb_t c;
		phase = 24'(64'(phase) + 64'(et) * 64'(speed_r));
		idx = (64'(phase) * 64'(COS_STEPS)) >> 24;
		level = cos_lut[idx[9:0]];
		c.r = shade_channel(base_r[23:16], anim_r[23:16], level, hold_r[0]);
		c.g = shade_channel(base_r[15:8], anim_r[15:8], level, hold_r[1]);
		c.b = shade_channel(base_r[7:0], anim_r[7:0], level, hold_r[2]);
		return c;
	endfunction

	function automatic void load_register(input reg_idx_t idx, input logic [23:0] v);
		case (idx)
			REG_SPEED: speed_r = v[15:0];
			REG_RADIUS: radius_r = v[15:0];
			REG_BASE_COLOR: base_r = v;
			REG_ANIM_COLOR: anim_r = v;
			REG_MULT_MODE: mult_r = v[0];
			REG_HOLD_MASK: hold_r = v[2:0];
			default: ;
		endcase
	endfunction

	function automatic step_t cfg_row(input reg_idx_t idx, input logic [23:0] v);
		return '{is_cfg: 1'b1, idx: idx, value: v, known: 1'b0, want: '0};
	endfunction

	function automatic step_t tick_row(input logic [15:0] et, input bit known, input rgb_t want);
		return '{is_cfg: 1'b0, idx: REG_SPEED, value: {8'd0, et}, known: known, want: want};
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [23:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		load_register(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_tick(input logic [15:0] et, input bit known, input rgb_t want);
		int gap;
		rgb_t c;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		elapsed_time = et;
		do @(posedge clk); while (in_stall);
		c = breathe_tick(et);
		pending_colors.push_back(known ? want : c);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected item r=%0d g=%0d b=%0d", $time,
					red_out, green_out, blue_out);
				fail_count++;
			end else begin
				want = pending_colors.pop_front();
				check_field("red_out", want.r, red_out);
				check_field("green_out", want.g, green_out);
				check_field("blue_out", want.b, blue_out);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("tb_light_color_breathing_animator: FAIL");
			$finish;
		end
	end

	initial begin
		step_t rows [$];
		int unsigned sent;
		int unsigned n;
		logic [23:0] v;
		logic [15:0] et;

		for (int k = 0; k < COS_STEPS; k++) begin
			cos_lut[k] = raised_cos_q16(k);
		end
		phase = '0;
		speed_r = 16'd256;
		radius_r = 16'd4096;
		base_r = 24'h000000;
		anim_r = 24'hFFFFFF;
		mult_r = 1'b0;
		hold_r = 3'd0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase 0 gives the table peak: full white from black in add mode
		rows.push_back(tick_row(16'h0000, 1'b1, '{8'hFF, 8'hFF, 8'hFF}));
		rows.push_back(tick_row(16'h0001, 1'b0, '0));
		rows.push_back(tick_row(16'hFFFF, 1'b0, '0));
		rows.push_back(cfg_row(REG_SPEED, 24'hFFFFFF));
		rows.push_back(tick_row(16'hFFFF, 1'b0, '0));
		rows.push_back(tick_row(16'h5555, 1'b0, '0));
		rows.push_back(tick_row(16'hAAAA, 1'b0, '0));
		rows.push_back(cfg_row(REG_BASE_COLOR, 24'h12AB7F));
		rows.push_back(cfg_row(REG_HOLD_MASK, 24'h000007));
		rows.push_back(tick_row(16'h1234, 1'b1, '{8'h12, 8'hAB, 8'h7F}));
		rows.push_back(cfg_row(REG_HOLD_MASK, 24'hFFFFFD));
		rows.push_back(tick_row(16'h0F0F, 1'b0, '0));
		rows.push_back(cfg_row(REG_HOLD_MASK, 24'h000000));
		rows.push_back(cfg_row(REG_RADIUS, 24'hFF0000));
		rows.push_back(tick_row(16'h00FF, 1'b1, '{8'h12, 8'hAB, 8'h7F}));
		rows.push_back(cfg_row(REG_MULT_MODE, 24'hFFFFFF));
		rows.push_back(tick_row(16'h8000, 1'b1, '{8'h00, 8'h00, 8'h00}));
		rows.push_back(cfg_row(REG_RADIUS, 24'h00FFFF));
		rows.push_back(cfg_row(REG_BASE_COLOR, 24'hFFFFFF));
		rows.push_back(tick_row(16'h0000, 1'b0, '0));
		rows.push_back(tick_row(16'h7FFF, 1'b0, '0));
		rows.push_back(cfg_row(REG_MULT_MODE, 24'hFFFFFE));
		rows.push_back(tick_row(16'h4321, 1'b1, '{8'hFF, 8'hFF, 8'hFF}));
		rows.push_back(cfg_row(REG_RSVD6, 24'h123456));
		rows.push_back(cfg_row(REG_RSVD7, 24'h000000));
		rows.push_back(tick_row(16'hC0DE, 1'b1, '{8'hFF, 8'hFF, 8'hFF}));
		rows.push_back(cfg_row(REG_ANIM_COLOR, 24'h000000));
		rows.push_back(cfg_row(REG_BASE_COLOR, 24'h000000));
		rows.push_back(cfg_row(REG_SPEED, 24'h000000));
		rows.push_back(tick_row(16'hFFFF, 1'b1, '{8'h00, 8'h00, 8'h00}));
		rows.push_back(cfg_row(REG_ANIM_COLOR, 24'h80FF01));
		rows.push_back(tick_row(16'h0003, 1'b0, '0));

		foreach (rows[k]) begin
			if (rows[k].is_cfg) begin
				wait_idle();
				cfg_write(rows[k].idx, rows[k].value);
			end else begin
				send_tick(rows[k].value[15:0], rows[k].known, rows[k].want);
			end
		end

		sent = 0;
		while (sent < RANDOM_TICKS) begin
			wait_idle();
			for (int r = REG_SPEED; r <= REG_HOLD_MASK; r++) begin
				v = 24'($urandom);
				case (r)
					REG_SPEED, REG_RADIUS: begin
						case ($urandom_range(0, 5))
							0: v[15:0] = 16'h0000;
							1: v[15:0] = 16'hFFFF;
							2: v[15:0] = 16'(r == REG_RADIUS ? 4096 : 256);
							3: v[15:0] = 16'($urandom_range(0, 8192));
							default: ;
						endcase
					end
					REG_BASE_COLOR, REG_ANIM_COLOR: begin
						case ($urandom_range(0, 4))
							0: v = 24'h000000;
							1: v = 24'hFFFFFF;
							default: ;
						endcase
					end
					REG_HOLD_MASK: begin
						if ($urandom_range(0, 2) != 0) begin
							v[2:0] = 3'd0;
						end
					end
					default: ;
				endcase
				cfg_write(reg_idx_t'(r), v);
			end
			if ($urandom_range(0, 3) == 0) begin
				cfg_write($urandom_range(0, 1) ? REG_RSVD6 : REG_RSVD7, 24'($urandom));
			end
			n = $urandom_range(20, 80);
			repeat (n) begin
				quiet = (sent >= RANDOM_TICKS - 100);
				case ($urandom_range(0, 7))
					0: et = 16'h0000;
					1: et = 16'hFFFF;
					2, 3: et = 16'($urandom_range(1, 64));
					default: et = 16'($urandom);
				endcase
				send_tick(et, 1'b0, '0);
				sent++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_colors.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_light_color_breathing_animator: PASS");
		end else begin
			$display("tb_light_color_breathing_animator: FAIL");
		end
		$finish;
	end

endmodule
